>>> rtl/dwh_pkg.sv
// Shared constants, types, microcode table and modular helpers for the DNA word hash set.
package dwh_pkg;

  localparam int TABLE_SIZE  = 4093;
  localparam int MAX_SYMBOLS = 12;
  localparam int SLOT_W      = 12;
  localparam int KEY_W       = 28;
  localparam int CNT_W       = 4;
  localparam int SYM_W       = 36;
  localparam int STATUS_W    = 3;
  localparam int STEP_W      = 3;
  localparam int COND_W      = 2;
  localparam int TX_W        = SLOT_W + 3;

  localparam logic [SLOT_W-1:0] SIZE_S    = SLOT_W'(TABLE_SIZE);
  localparam logic [SLOT_W-1:0] SIZE_M1   = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W:0]   SIZE_X    = (SLOT_W + 1)'(TABLE_SIZE);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_SYMBOLS);

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  localparam logic [STEP_W-1:0] STEP_CLEAR = 3'd0;
  localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HASH  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_SETUP = 3'd3;
  localparam logic [STEP_W-1:0] STEP_PROBE = 3'd4;

  localparam logic [COND_W-1:0] COND_ALWAYS   = 2'd0;
  localparam logic [COND_W-1:0] COND_CLR_DONE = 2'd1;
  localparam logic [COND_W-1:0] COND_IN_ACC   = 2'd2;
  localparam logic [COND_W-1:0] COND_DONE     = 2'd3;

  typedef struct packed {
    logic              accept;
    logic              hash;
    logic              setup;
    logic              probe;
    logic              clear;
    logic [COND_W-1:0] cond;
    logic              loop;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic clr_done;
    logic in_acc;
    logic sym_done;
    logic probe_end;
  } flags_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      STEP_CLEAR: begin
        w.clear = 1'b1; w.cond = COND_CLR_DONE; w.loop = 1'b1; w.target = STEP_WAIT;
      end
      STEP_WAIT: begin
        w.accept = 1'b1; w.cond = COND_IN_ACC; w.loop = 1'b1; w.target = STEP_HASH;
      end
      STEP_HASH: begin
        w.hash = 1'b1; w.cond = COND_DONE; w.loop = 1'b1; w.target = STEP_SETUP;
      end
      STEP_SETUP: begin
        w.setup = 1'b1; w.cond = COND_ALWAYS; w.loop = 1'b0; w.target = STEP_PROBE;
      end
      STEP_PROBE: begin
        w.probe = 1'b1; w.cond = COND_DONE; w.loop = 1'b1; w.target = STEP_WAIT;
      end
      default: begin
        w.cond = COND_ALWAYS; w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  // Returns (r * 5 + code) mod m for r below m.
  function automatic logic [SLOT_W-1:0] mod5_step(input logic [SLOT_W-1:0] r,
                                                  input logic [2:0] code,
                                                  input logic [SLOT_W-1:0] m);
    logic [TX_W-1:0] t;
    logic [TX_W-1:0] m1;
    logic [TX_W-1:0] m2;
    logic [TX_W-1:0] m3;
    logic [TX_W-1:0] m4;
    logic [TX_W-1:0] sub;
    t   = TX_W'({r, 2'b00}) + TX_W'(r) + TX_W'(code);
    m1  = TX_W'(m);
    m2  = {m1[TX_W-2:0], 1'b0};
    m3  = m2 + m1;
    m4  = {m1[TX_W-3:0], 2'b00};
    if (t >= m4) begin
      sub = m4;
    end else if (t >= m3) begin
      sub = m3;
    end else if (t >= m2) begin
      sub = m2;
    end else if (t >= m1) begin
      sub = m1;
    end else begin
      sub = '0;
    end
    t = t - sub;
    return t[SLOT_W-1:0];
  endfunction

endpackage

>>> rtl/dwh_table.sv
// Key table memory with one write port and one registered read port.
module dwh_table
  import dwh_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [KEY_W-1:0]  wdata,
  input  logic [SLOT_W-1:0] raddr,
  output logic [KEY_W-1:0]  rdata
);

  logic [KEY_W-1:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dwh_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module dwh_seq
  import dwh_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              taken;

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_CLR_DONE: taken = flags.clr_done;
      COND_IN_ACC:   taken = flags.in_acc;
      COND_DONE:     taken = ctrl.probe ? flags.probe_end : flags.sym_done;
      default:       taken = 1'b1;
    endcase
    if (taken) begin
      step_next = ctrl.target;
    end else if (ctrl.loop) begin
      step_next = step;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_CLEAR;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/dwh_path.sv
// Datapath: key and hash accumulation, probe walk, table access and result selection.
module dwh_path
  import dwh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  logic                in_acc,
  input  logic                operation,
  input  logic [SYM_W-1:0]    word_symbols,
  input  logic [CNT_W-1:0]    word_length,
  input  logic                out_free,
  output flags_t              flags,
  output logic                res_load,
  output logic [STATUS_W-1:0] res_status,
  output logic [SLOT_W-1:0]   res_slot
);

  logic                op;
  logic [SYM_W-1:0]    syms;
  logic [CNT_W-1:0]    cnt;
  logic [KEY_W-1:0]    key;
  logic [SLOT_W-1:0]   moda;
  logic [SLOT_W-1:0]   modb;
  logic [SLOT_W-1:0]   stride;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   probes;
  logic [SLOT_W-1:0]   clr_addr;

  logic [CNT_W-1:0]    idx;
  logic [5:0]          pos;
  logic [2:0]          raw;
  logic [2:0]          code;
  logic [SLOT_W:0]     sum;
  logic [SLOT_W-1:0]   slot_next;
  logic [KEY_W-1:0]    rdata;
  logic                hit;
  logic                empty;
  logic                last;
  logic                term;
  logic                we;
  logic [SLOT_W-1:0]   waddr;
  logic [KEY_W-1:0]    wdata;
  logic [SLOT_W-1:0]   raddr;

  assign idx  = cnt - CNT_W'(1);
  assign pos  = {1'b0, idx, 1'b0} + {2'b00, idx};
  assign raw  = syms[pos +: 3];
  assign code = (raw > 3'd4) ? 3'd0 : raw;

  assign sum       = {1'b0, slot} + {1'b0, stride};
  assign slot_next = (sum >= SIZE_X) ? SLOT_W'(sum - SIZE_X) : sum[SLOT_W-1:0];

  assign hit   = (rdata == key);
  assign empty = (rdata == '0);
  assign last  = (probes == LAST_SLOT);
  assign term  = hit | empty | last;

  assign res_load = ctrl.probe & term & out_free;

  always_comb begin
    if (hit) begin
      res_status = (op == OP_FIND) ? ST_FOUND : ST_PRESENT;
      res_slot   = slot;
    end else if (empty) begin
      res_status = (op == OP_FIND) ? ST_MISSING : ST_INSERTED;
      res_slot   = slot;
    end else begin
      res_status = ST_FULL;
      res_slot   = '0;
    end
  end

  assign flags.clr_done  = (clr_addr == LAST_SLOT);
  assign flags.in_acc    = in_acc;
  assign flags.sym_done  = (cnt == '0);
  assign flags.probe_end = term & out_free;

  always_comb begin
    we    = 1'b0;
    waddr = slot;
    wdata = key;
    if (ctrl.clear) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (res_load && !hit && empty && op == OP_INSERT) begin
      we = 1'b1;
    end
    if (ctrl.setup) begin
      raddr = moda;
    end else if (ctrl.probe && !term) begin
      raddr = slot_next;
    end else begin
      raddr = slot;
    end
  end

  dwh_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctrl.clear && !flags.clr_done) begin
      clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op   <= operation;
      syms <= word_symbols;
      cnt  <= (word_length > MAX_CNT) ? MAX_CNT : word_length;
      key  <= '0;
      moda <= '0;
      modb <= '0;
    end else if (ctrl.hash && !flags.sym_done) begin
      key  <= {key[KEY_W-3:0], 2'b00} + key + KEY_W'(code);
      moda <= mod5_step(moda, code, SIZE_S);
      modb <= mod5_step(modb, code, SIZE_M1);
      cnt  <= idx;
    end
    if (ctrl.setup) begin
      slot   <= moda;
      stride <= modb + SLOT_W'(1);
      probes <= '0;
    end else if (ctrl.probe && !term) begin
      slot   <= slot_next;
      probes <= probes + SLOT_W'(1);
    end
  end

endmodule

>>> rtl/dna_word_double_hash_set.sv
// Top level of the DNA word hash set with double hashing probe walk.
//
//   channel  direction  signals                                      request
//   in       input      in_valid/in_ready, operation, word_symbols,  one insert or find
//                       word_length
//   out      output     out_valid/out_ready, status, slot_index      one result
//
// An item is accepted, hashed one symbol at a time over up to 12 symbols, set up and then probed one entry at a time.
// The probe loop reads one table entry per cycle from a single read port.
// After reset the table is cleared one entry per cycle, all 4093 entries; no request is taken then.
// The result waits in an output register; the last probe is held while it is full and not drained.
module dna_word_double_hash_set
  import dwh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [SYM_W-1:0]    word_symbols,
  input  logic [CNT_W-1:0]    word_length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_index
);

  ctrl_t               ctrl;
  flags_t              flags;
  logic                in_acc;
  logic                out_free;
  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;

  assign in_ready = ctrl.accept;
  assign in_acc   = in_valid & ctrl.accept;
  assign out_free = !out_valid | out_ready;

  dwh_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  dwh_path u_path (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .in_acc       (in_acc),
    .operation    (operation),
    .word_symbols (word_symbols),
    .word_length  (word_length),
    .out_free     (out_free),
    .flags        (flags),
    .res_load     (res_load),
    .res_status   (res_status),
    .res_slot     (res_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status     <= res_status;
      slot_index <= res_slot;
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_load |-> (!out_valid || out_ready))
    else $error("Result loaded while the output register still held a result.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (slot_index == '0))
    else $error("A full table result carries a nonzero slot.");

  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("A new request was offered ready before the previous one finished.");

  assert property (@(posedge clk) disable iff (rst) res_load |=> out_valid)
    else $error("A loaded result did not appear at the output.");

endmodule
